// ===== rtl/core/rqt_pkg.sv =====
// Shared types and constants for the retransmit queue tracker.
package rqt_pkg;

    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 8;
    localparam int IVL_W   = 16;
    localparam int PLEN_W  = 12;
    localparam int MODE_W  = 3;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 6;
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ACK     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RETX    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TIMEOUT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [1:0] REG_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
    localparam logic [1:0] REG_PLEN_LIMIT  = 2'd2;

    localparam logic [IVL_W-1:0]   INTERVAL_RST    = 16'd1000;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 8'd8;
    localparam logic [PLEN_W-1:0]  PLEN_LIMIT_RST  = 12'd512;
    localparam logic [RETRY_W-1:0] RETRY_MAX       = 8'hFF;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [TIME_W-1:0]  tx_stamp;
        logic [RETRY_W-1:0] retries;
    } t_entry;

    typedef struct packed {
        logic [IVL_W-1:0]   interval;
        logic [RETRY_W-1:0] retry_limit;
        logic [PLEN_W-1:0]  plen_limit;
    } t_cfg;

endpackage

// ===== rtl/core/rqt_regs.sv =====
// APB configuration registers of the retransmit queue tracker.
module rqt_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqt_pkg::APB_AW-1:0] paddr,
    input  logic [rqt_pkg::APB_DW-1:0] pwdata,
    output logic [rqt_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output rqt_pkg::t_cfg              o_cfg
);

    rqt_pkg::t_cfg r_cfg;
    logic [1:0]    reg_idx;
    logic          wr_go;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_go   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval    <= rqt_pkg::INTERVAL_RST;
            r_cfg.retry_limit <= rqt_pkg::RETRY_LIMIT_RST;
            r_cfg.plen_limit  <= rqt_pkg::PLEN_LIMIT_RST;
        end else if (wr_go) begin
            unique case (reg_idx)
                rqt_pkg::REG_INTERVAL:    r_cfg.interval    <= pwdata[rqt_pkg::IVL_W-1:0];
                rqt_pkg::REG_RETRY_LIMIT: r_cfg.retry_limit <= pwdata[rqt_pkg::RETRY_W-1:0];
                rqt_pkg::REG_PLEN_LIMIT:  r_cfg.plen_limit  <= pwdata[rqt_pkg::PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rqt_pkg::REG_INTERVAL:    prdata = rqt_pkg::APB_DW'(r_cfg.interval);
            rqt_pkg::REG_RETRY_LIMIT: prdata = rqt_pkg::APB_DW'(r_cfg.retry_limit);
            rqt_pkg::REG_PLEN_LIMIT:  prdata = rqt_pkg::APB_DW'(r_cfg.plen_limit);
            default:                  prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/rqt_match.sv =====
// Shared per-entry compare unit: one slot tested against the current mode.
module rqt_match (
    input  logic [rqt_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_active,
    input  rqt_pkg::t_entry            i_entry,
    input  logic [rqt_pkg::SEQ_W-1:0]  i_seq,
    input  logic [rqt_pkg::TIME_W-1:0] i_now,
    input  rqt_pkg::t_cfg              i_cfg,
    output logic                       o_hit
);

    logic [rqt_pkg::TIME_W-1:0] age;

    assign age = i_now - i_entry.tx_stamp;

    always_comb begin
        unique case (i_mode)
            rqt_pkg::MODE_ADD:     o_hit = !i_active;
            rqt_pkg::MODE_ACK:     o_hit = i_active && (i_entry.seq == i_seq);
            rqt_pkg::MODE_RETX:
                o_hit = i_active && (age >= rqt_pkg::TIME_W'(i_cfg.interval));
            rqt_pkg::MODE_TIMEOUT: o_hit = i_active && (i_entry.retries >= i_cfg.retry_limit);
            default:               o_hit = 1'b0;
        endcase
    end

endmodule

// ===== rtl/core/rqt_entry_mem.sv =====
// Slot table memory: one write port, one registered read port.
module rqt_entry_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  rqt_pkg::t_entry i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output rqt_pkg::t_entry o_rd_data
);

    rqt_pkg::t_entry r_mem [DEPTH];
    rqt_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/rqt_ctrl.sv =====
// Scan sequencer: walks the slots one per cycle through the shared compare unit.
module rqt_ctrl #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rqt_pkg::t_cfg              i_cfg,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [rqt_pkg::MODE_W-1:0] i_mode,
    input  logic [rqt_pkg::SEQ_W-1:0]  i_seq,
    input  logic [rqt_pkg::TIME_W-1:0] i_now,
    input  logic [rqt_pkg::PLEN_W-1:0] i_plen,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic                       o_ok,
    output logic [rqt_pkg::SLOT_W-1:0] o_slot,
    output logic [rqt_pkg::CNT_W-1:0]  o_count,
    output logic [AW-1:0]              o_rd_addr,
    input  rqt_pkg::t_entry            i_rd_data,
    output logic                       o_wr_en,
    output logic [AW-1:0]              o_wr_addr,
    output rqt_pkg::t_entry            o_wr_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_state                     r_state;
    logic [rqt_pkg::MODE_W-1:0] r_mode;
    logic [rqt_pkg::SEQ_W-1:0]  r_seq;
    logic [rqt_pkg::TIME_W-1:0] r_now;
    logic [AW-1:0]              r_rd_idx;
    logic [AW-1:0]              r_cmp_idx;
    logic                       r_cmp_vld;
    logic [DEPTH-1:0]           r_active;
    logic [CW-1:0]              r_count;
    logic                       r_ok;
    logic [AW-1:0]              r_slot;
    logic                       r_m_valid;
    logic                       r_m_ok;
    logic [rqt_pkg::SLOT_W-1:0] r_m_slot;
    logic [rqt_pkg::CNT_W-1:0]  r_m_count;

    logic hit;
    logic scan_hit;
    logic accept;

    rqt_match u_match (
        .i_mode  (r_mode),
        .i_active(r_active[r_cmp_idx]),
        .i_entry (i_rd_data),
        .i_seq   (r_seq),
        .i_now   (r_now),
        .i_cfg   (i_cfg),
        .o_hit   (hit)
    );

    assign scan_hit   = (r_state == S_SCAN) && r_cmp_vld && hit;
    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_rd_addr  = r_rd_idx;
    assign o_wr_addr  = r_cmp_idx;
    assign o_wr_en    = scan_hit &&
                        (r_mode == rqt_pkg::MODE_ADD || r_mode == rqt_pkg::MODE_RETX);

    always_comb begin
        if (r_mode == rqt_pkg::MODE_ADD) begin
            o_wr_data.seq     = r_seq;
            o_wr_data.retries = '0;
        end else begin
            o_wr_data.seq     = i_rd_data.seq;
            o_wr_data.retries = (i_rd_data.retries == rqt_pkg::RETRY_MAX) ?
                                i_rd_data.retries : i_rd_data.retries + 1'b1;
        end
        o_wr_data.tx_stamp = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (r_m_valid && i_m_tready && r_state != S_FIN) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode    <= i_mode;
                        r_seq     <= i_seq;
                        r_now     <= i_now;
                        r_rd_idx  <= '0;
                        r_cmp_vld <= 1'b0;
                        r_ok      <= (i_mode == rqt_pkg::MODE_CLEAR);
                        r_slot    <= '0;
                        priority if (i_mode == rqt_pkg::MODE_CLEAR) begin
                            r_active <= '0;
                            r_count  <= '0;
                            r_state  <= S_FIN;
                        end else if (i_mode == rqt_pkg::MODE_ADD &&
                                     i_plen > i_cfg.plen_limit) begin
                            r_state <= S_FIN;
                        end else if (i_mode == rqt_pkg::MODE_ADD ||
                                     i_mode == rqt_pkg::MODE_ACK ||
                                     i_mode == rqt_pkg::MODE_RETX ||
                                     i_mode == rqt_pkg::MODE_TIMEOUT) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_idx  <= r_rd_idx + 1'b1;
                    r_cmp_idx <= r_rd_idx;
                    r_cmp_vld <= 1'b1;
                    if (scan_hit) begin
                        r_ok    <= 1'b1;
                        r_state <= S_FIN;
                        if (r_mode == rqt_pkg::MODE_ADD) begin
                            r_active[r_cmp_idx] <= 1'b1;
                            r_count             <= r_count + 1'b1;
                            r_slot              <= r_cmp_idx;
                        end else if (r_mode == rqt_pkg::MODE_ACK) begin
                            r_active[r_cmp_idx] <= 1'b0;
                            r_count             <= r_count - 1'b1;
                        end else if (r_mode == rqt_pkg::MODE_RETX) begin
                            r_slot <= r_cmp_idx;
                        end
                    end else if (r_cmp_vld && r_cmp_idx == LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_ok    <= r_ok;
                        r_m_slot  <= rqt_pkg::SLOT_W'(r_slot);
                        r_m_count <= rqt_pkg::CNT_W'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_ok       = r_m_ok;
    assign o_slot     = r_m_slot;
    assign o_count    = r_m_count;

endmodule

// ===== rtl/core/retransmit_queue_tracker.sv =====
// Top level of the retransmit queue tracker: slot table, scan sequencer, APB registers.
//
//  channel   | dir | transfer when           | contents
//  s stream  | in  | i_s_tvalid & o_s_tready | mode, seq_number, now_time_ms, payload_length
//  m stream  | out | o_m_tvalid & i_m_tready | ok, slot, entry_count
//  apb       | in  | psel&penable&pwrite     | interval, retry limit, payload limit
//
// Add, ack, retransmit and timeout checks walk the table one slot per cycle
// through one compare unit fed by a registered memory read, and stop early on
// a hit. Clear, rejected adds and unused modes skip the scan and go straight
// to the result register. No clearing pass after reset. A stalled output holds
// its result; the next item may be taken meanwhile.
module retransmit_queue_tracker #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // [2:0] mode, [18:3] seq_number, [50:19] now_time_ms, [62:51] payload_length
    input  logic [63:0]                i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // [0] ok, [5:1] slot, [11:6] entry_count
    output logic [15:0]                o_m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rqt_pkg::APB_AW-1:0] paddr,
    input  logic [rqt_pkg::APB_DW-1:0] pwdata,
    output logic [rqt_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rqt_pkg::t_cfg              cfg;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic                       wr_en;
    rqt_pkg::t_entry            rd_data;
    rqt_pkg::t_entry            wr_data;
    logic                       ok;
    logic [rqt_pkg::SLOT_W-1:0] slot;
    logic [rqt_pkg::CNT_W-1:0]  count;

    rqt_regs u_regs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg)
    );

    rqt_entry_mem #(
        .DEPTH(QUEUE_DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    rqt_ctrl #(
        .DEPTH(QUEUE_DEPTH),
        .AW   (AW),
        .CW   (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_mode    (i_s_tdata[2:0]),
        .i_seq     (i_s_tdata[18:3]),
        .i_now     (i_s_tdata[50:19]),
        .i_plen    (i_s_tdata[62:51]),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_ok      (ok),
        .o_slot    (slot),
        .o_count   (count),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    assign o_m_tdata = {4'b0000, count, slot, ok};

endmodule

// ===== rtl/core/rqt_checker.sv =====
// Port-level checks for the retransmit queue tracker, bound to the top level.
module rqt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken again right after a transfer");

    a_slot_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[5:1] == 5'd0))
        else $error("nonzero slot on a failed result");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind retransmit_queue_tracker rqt_checker u_rqt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata)
);
